// ===== rtl/spd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants
// Widths, history depth and the control bundle that drives each history cell.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int unsigned ID_W    = 64;
	localparam int unsigned K_W     = 4;
	localparam int unsigned DEPTH   = 8;
	localparam logic [K_W-1:0] K_RESET = 4'd4;
	localparam logic [K_W-1:0] K_MIN   = 4'd1;
	localparam logic [K_W-1:0] K_MAX   = K_W'(DEPTH);

	typedef logic [ID_W-1:0] block_t;
	typedef logic [K_W-1:0]  k_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

// ===== rtl/spd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_if: stream channels
// Access channel into the detector and result channel out of it.
// ----------------------------------------------------------------------------
interface spd_req_if;
	logic            valid;
	logic            ready;
	spd_pkg::block_t block_id;

	modport source (output valid, output block_id, input ready);
	modport sink   (input valid, input block_id, output ready);
endinterface

interface spd_rsp_if;
	logic            valid;
	logic            ready;
	logic            prefetch_valid;
	spd_pkg::block_t prefetch_block;

	modport source (output valid, output prefetch_valid, output prefetch_block, input ready);
	modport sink   (input valid, input prefetch_valid, input prefetch_block, output ready);
endinterface

// ===== rtl/spd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_cell: one history entry
// Holds one past block number, shifts it to the next cell on each transfer
// and checks it against the current block number minus this cell's offset.
// ----------------------------------------------------------------------------
module spd_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  spd_pkg::cell_ctrl_t ctrl,
	input  spd_pkg::block_t     shift_in,
	input  spd_pkg::block_t     block_id,
	input  spd_pkg::k_t         offset,
	output spd_pkg::block_t     entry,
	output logic                match
);

	spd_pkg::block_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '1;
		end else if (ctrl.clear) begin
			entry_q <= '1;
		end else if (ctrl.shift) begin
			entry_q <= shift_in;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == (block_id - spd_pkg::ID_W'(offset)));

endmodule

// ===== rtl/sequential_stream_prefetch_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_stream_prefetch_detector_top: sequential stream prefetch detector
// Keeps the last block numbers in a chain of cells and requests a prefetch
// of the next block when the last k accesses ran up to the current one.
//
//   channel  dir  payload                          handshake
//   req      in   block_id[63:0]                   valid/ready
//   rsp      out  prefetch_valid, prefetch_block   valid/ready
//   cfg      in   cfg_wdata[3:0] (confidence_k)    cfg_we, no wait
//
// One access per cycle unless a result sits unclaimed; the result is captured
// in the output register at the transfer. All cells compare in parallel
// against the access in the same cycle the history shifts. req.ready is low
// only while a result sits unclaimed in the output register. Reset sets k to 4
// and the history to all ones; a cfg write clears the history again.
// ----------------------------------------------------------------------------
module sequential_stream_prefetch_detector_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  spd_pkg::k_t      cfg_wdata,
	spd_req_if.sink          req,
	spd_rsp_if.source        rsp
);

	spd_pkg::k_t         k_q;
	spd_pkg::k_t         k_eff;
	spd_pkg::cell_ctrl_t ctrl;
	spd_pkg::block_t     entry [spd_pkg::DEPTH];
	logic [spd_pkg::DEPTH-1:0] match;
	logic [spd_pkg::DEPTH-1:0] hit;
	logic                req_xfer;
	logic                seq;

	logic            out_valid_q;
	logic            out_flag_q;
	spd_pkg::block_t out_block_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= spd_pkg::K_RESET;
		end else if (cfg_we) begin
			k_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (k_q < spd_pkg::K_MIN) begin
			k_eff = spd_pkg::K_MIN;
		end else if (k_q > spd_pkg::K_MAX) begin
			k_eff = spd_pkg::K_MAX;
		end else begin
			k_eff = k_q;
		end
	end

	assign req.ready  = !out_valid_q || rsp.ready;
	assign req_xfer   = req.valid && req.ready;
	assign ctrl.shift = req_xfer;
	assign ctrl.clear = cfg_we;

	for (genvar j = 0; j < spd_pkg::DEPTH; j++) begin : g_cell
		spd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.shift_in ((j == 0) ? req.block_id : entry[(j == 0) ? 0 : j - 1]),
			.block_id (req.block_id),
			.offset   (spd_pkg::K_W'(j + 1)),
			.entry    (entry[j]),
			.match    (match[j])
		);
		// cells beyond k do not take part
		assign hit[j] = match[j] || (spd_pkg::K_W'(j + 1) > k_eff);
	end

	assign seq = &hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_xfer) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			out_flag_q  <= seq;
			out_block_q <= seq ? (req.block_id + spd_pkg::ID_W'(1)) : '0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.prefetch_valid = out_flag_q;
	assign rsp.prefetch_block = out_block_q;

endmodule

// ===== rtl/spd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_checker: port-level checks
// Watches the top level's channels and flags broken result behavior.
// ----------------------------------------------------------------------------
module spd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input spd_pkg::block_t req_block_id,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input logic            rsp_prefetch_valid,
	input spd_pkg::block_t rsp_prefetch_block
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no result after access transfer");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("access stalled with empty output");

	a_no_pf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_prefetch_valid |-> rsp_prefetch_block == '0)
		else $error("prefetch block nonzero without prefetch");

	a_pf_next: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=>
			!rsp_prefetch_valid ||
			rsp_prefetch_block == $past(req_block_id) + spd_pkg::ID_W'(1))
		else $error("prefetch block is not the next block");

endmodule

bind sequential_stream_prefetch_detector_top spd_checker u_spd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.req_block_id       (req.block_id),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_prefetch_valid (rsp.prefetch_valid),
	.rsp_prefetch_block (rsp.prefetch_block)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sequential stream prefetch detector
// Drives block numbers through the access channel and checks every result
// against a cycle-free model of the access history. The model is updated
// on each accepted transfer and on each confidence_k write. The run covers
// directed streams, including wrap-around, the all-ones history after a
// clear, and k values out of range. Random runs of sequential accesses
// follow, mixed with breaks, under several k settings and idle patterns,
// plus one long stall on the result side.
// ----------------------------------------------------------------------------
import spd_pkg::*;

typedef struct packed {
	logic   hit;
	block_t next_block;
} prefetch_t;

class stream_scoreboard;
	block_t      history[DEPTH];
	k_t          conf_k;
	prefetch_t   pending_prefetches[$];
	int unsigned mismatches;

	function new();
		mismatches = 0;
		write_k(K_RESET);
	endfunction

	function void write_k(k_t value);
		conf_k = value;
		foreach (history[j])
			history[j] = '1;
	endfunction

	function prefetch_t predict_prefetch(block_t id);
		int unsigned k;
		prefetch_t   r;
		k = conf_k;
		if (k < K_MIN)
			k = K_MIN;
		if (k > K_MAX)
			k = K_MAX;
		r.hit = 1'b1;
		for (int i = 1; i <= k; i++)
			if (history[i-1] != id - 64'(i))
				r.hit = 1'b0;
		for (int j = DEPTH - 1; j > 0; j--)
			history[j] = history[j-1];
		history[0] = id;
		r.next_block = r.hit ? id + 64'd1 : '0;
		return r;
	endfunction

	function void note_access(block_t id);
		pending_prefetches.push_back(predict_prefetch(id));
	endfunction

	function void log_mismatch(string what, block_t want, block_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
	endfunction

	function void check_result(logic got_hit, block_t got_block);
		prefetch_t want;
		if (pending_prefetches.size() == 0) begin
			log_mismatch("result with no access pending", '0, got_block);
			return;
		end
		want = pending_prefetches.pop_front();
		if (got_hit !== want.hit)
			log_mismatch("prefetch_valid", 64'(want.hit), 64'(got_hit));
		if (got_block !== want.next_block)
			log_mismatch("prefetch_block", want.next_block, got_block);
	endfunction
endclass

module testbench;
	logic clk;
	logic arst_n;
	logic cfg_we;
	k_t   cfg_wdata;

	spd_req_if req_ch();
	spd_rsp_if rsp_ch();

	stream_scoreboard sb = new();

	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	logic        hold_rsp;
	block_t      last_id;

	sequential_stream_prefetch_detector_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.prefetch_valid, rsp_ch.prefetch_block);
			if (req_ch.valid && req_ch.ready)
				sb.note_access(req_ch.block_id);
			if (cfg_we)
				sb.write_k(cfg_wdata);
		end
	end

	task send_access(block_t id);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.block_id <= id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		last_id = id;
		@(negedge clk);
	endtask

	task write_k(k_t value);
		req_ch.valid <= 1'b0;
		while (sb.pending_prefetches.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task send_run(block_t base, int unsigned len);
		for (int unsigned j = 0; j < len; j++)
			send_access(base + 64'(j));
	endtask

	task send_stream(int unsigned count);
		int unsigned sent;
		int unsigned mode;
		int unsigned len;
		block_t      base;
		sent = 0;
		while (sent < count) begin
			mode = $urandom_range(9);
			if (mode < 7) begin
				case ($urandom_range(7))
					0: base = '1 - 64'($urandom_range(12));
					1: base = 64'($urandom_range(12));
					default: base = {$urandom, $urandom};
				endcase
				len = $urandom_range(1, 12);
				if (len > count - sent)
					len = count - sent;
				send_run(base, len);
				sent += len;
			end else begin
				case (mode)
					7: send_access({$urandom, $urandom});
					8: send_access(last_id);
					default: send_access(last_id + 64'd2);
				endcase
				sent++;
			end
		end
	endtask

	task run_phase(int unsigned src_pct, int unsigned snk_pct, bit with_hold);
		k_t kv;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int s = 0; s < 5; s++) begin
			case (s)
				0: kv = K_MIN;
				1: kv = K_MAX;
				2: kv = '0;
				3: kv = '1;
				default: kv = k_t'($urandom_range(15));
			endcase
			write_k(kv);
			if (with_hold && s == 0) begin
				fork
					begin
						@(posedge clk);
						hold_rsp = 1'b1;
						repeat (300) @(posedge clk);
						hold_rsp = 1'b0;
					end
					send_stream(105);
				join
			end else begin
				send_stream(105);
			end
		end
	endtask

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned drain;
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		req_ch.valid    = 1'b0;
		req_ch.block_id = '0;
		rsp_ch.ready    = 1'b0;
		hold_rsp        = 1'b0;
		src_idle_pct    = 0;
		snk_idle_pct    = 0;
		last_id         = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset k, plain stream then a run that wraps through zero
		send_run(64'd10, 5);
		send_run('1 - 64'd4, 7);
		// k of one sees the all-ones history as block minus one
		write_k(K_MIN);
		send_access('0);
		send_access('0);
		send_access(64'd1);
		write_k('0);
		send_access('0);
		// k above depth acts as depth; a rewrite clears the history
		write_k('1);
		send_run(64'h7fff_ffff_ffff_fffc, 9);
		write_k('1);
		send_access(64'h8000_0000_0000_0005);

		run_phase(33, 86, 1'b0);
		run_phase(86, 33, 1'b0);
		run_phase(0, 0, 1'b1);

		req_ch.valid <= 1'b0;
		drain = 0;
		while (sb.pending_prefetches.size() != 0 && drain < 10000) begin
			@(negedge clk);
			drain++;
		end
		repeat (5) @(negedge clk);
		if (sb.pending_prefetches.size() != 0)
			$display("%0d results never arrived", sb.pending_prefetches.size());
		if (sb.mismatches == 0 && sb.pending_prefetches.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
